// ----- hdl/eul2q_pkg.sv -----
// ----------------------------------------------------------------------------
// eul2q_pkg
// Shared constants, types and arithmetic helpers for the Euler angle to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package eul2q_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  localparam int WORK_FRAC     = 30;
  localparam int CORDIC_STAGES = 30;
  localparam int SQRT_STAGES   = 32;
  localparam int DIV_STAGES    = 31;

  localparam int CW     = 34;  // CORDIC x and y
  localparam int ZW     = 33;  // CORDIC residual phase
  localparam int SCW    = 32;  // sine and cosine
  localparam int MW     = 36;  // matrix and quaternion working width
  localparam int MUL_W  = 33;  // multiplier operand width
  localparam int SQW    = 64;  // square root radicand
  localparam int RADW   = 34;  // clamped radicand
  localparam int DOMW   = 31;  // dominant component
  localparam int DENW   = 33;  // reciprocal denominator
  localparam int RCPW   = 31;  // reciprocal

  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

  localparam logic [31:0] ATAN_PHASE [CORDIC_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  localparam logic [1:0] SEL_W = 2'd0;
  localparam logic [1:0] SEL_X = 2'd1;
  localparam logic [1:0] SEL_Y = 2'd2;
  localparam logic [1:0] SEL_Z = 2'd3;

  typedef logic signed [MW-1:0] work_t;

  typedef struct packed {
    work_t      p0;
    work_t      p1;
    work_t      p2;
    logic [1:0] sel;
  } side_t;

  function automatic work_t qmul(input logic signed [MUL_W-1:0] a,
                                 input logic signed [MUL_W-1:0] b);
    logic signed [2*MUL_W-1:0] prod;
    prod = a * b + (2*MUL_W)'(64'sd1 <<< (WORK_FRAC - 1));
    return MW'(prod >>> WORK_FRAC);
  endfunction

endpackage

// ----- hdl/eul2q_angles_if.sv -----
// ----------------------------------------------------------------------------
// eul2q_angles_if
// Input channel: roll, pitch and yaw as binary angles.
// ----------------------------------------------------------------------------
interface eul2q_angles_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;

  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle,
                  input yaw_angle, output ready);
endinterface

// ----- hdl/eul2q_quat_if.sv -----
// ----------------------------------------------------------------------------
// eul2q_quat_if
// Output channel: unit quaternion in Q2.14 and the dominant component.
// ----------------------------------------------------------------------------
interface eul2q_quat_if;
  logic               valid;
  logic               ready;
  logic        [14:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic        [1:0]  dominant_case;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, output dominant_case, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, input dominant_case, output ready);
endinterface

// ----- hdl/eul2q_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// eul2q_cordic_cell
// One rotation-mode CORDIC micro-rotation with its pipeline register.
// ----------------------------------------------------------------------------
module eul2q_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [eul2q_pkg::CW-1:0]    x_in,
  input  logic signed [eul2q_pkg::CW-1:0]    y_in,
  input  logic signed [eul2q_pkg::ZW-1:0]    z_in,
  input  logic                               flip_in,
  output logic signed [eul2q_pkg::CW-1:0]    x_out,
  output logic signed [eul2q_pkg::CW-1:0]    y_out,
  output logic signed [eul2q_pkg::ZW-1:0]    z_out,
  output logic                               flip_out
);
  import eul2q_pkg::*;

  logic signed [ZW-1:0] step;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  assign step = $signed({1'b0, ATAN_PHASE[STAGE]});
  assign dx   = y_in >>> STAGE;
  assign dy   = x_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ZW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - step;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + step;
      end
      flip_out <= flip_in;
    end
  end

endmodule

// ----- hdl/eul2q_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// eul2q_sqrt_cell
// One digit of the bitwise integer square root with its pipeline register.
// ----------------------------------------------------------------------------
module eul2q_sqrt_cell #(
  parameter int STAGE = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [eul2q_pkg::SQW-1:0]     v_in,
  input  logic [eul2q_pkg::SQW-1:0]     res_in,
  output logic [eul2q_pkg::SQW-1:0]     v_out,
  output logic [eul2q_pkg::SQW-1:0]     res_out
);
  import eul2q_pkg::*;

  localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * STAGE);

  logic [SQW:0] trial;

  assign trial = {1'b0, res_in} + {1'b0, BIT};

  always_ff @(posedge clk) begin
    if (en) begin
      if ({1'b0, v_in} >= trial) begin
        v_out   <= v_in - trial[SQW-1:0];
        res_out <= (res_in >> 1) + BIT;
      end else begin
        v_out   <= v_in;
        res_out <= res_in >> 1;
      end
    end
  end

endmodule

// ----- hdl/eul2q_div_cell.sv -----
// ----------------------------------------------------------------------------
// eul2q_div_cell
// One quotient bit of the restoring reciprocal division.
// ----------------------------------------------------------------------------
module eul2q_div_cell #(
  parameter int BITPOS = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [eul2q_pkg::DENW-1:0]    rem_in,
  input  logic [eul2q_pkg::DENW-1:0]    den_in,
  input  logic [eul2q_pkg::RCPW-1:0]    num_in,
  input  logic [eul2q_pkg::RCPW-1:0]    quo_in,
  output logic [eul2q_pkg::DENW-1:0]    rem_out,
  output logic [eul2q_pkg::DENW-1:0]    den_out,
  output logic [eul2q_pkg::RCPW-1:0]    num_out,
  output logic [eul2q_pkg::RCPW-1:0]    quo_out
);
  import eul2q_pkg::*;

  logic [DENW:0] trial;

  assign trial = {rem_in, num_in[BITPOS]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (trial >= {1'b0, den_in}) begin
        rem_out <= DENW'(trial - {1'b0, den_in});
        quo_out <= quo_in | (RCPW'(1) << BITPOS);
      end else begin
        rem_out <= trial[DENW-1:0];
        quo_out <= quo_in;
      end
      den_out <= den_in;
      num_out <= num_in;
    end
  end

endmodule

// ----- hdl/euler_to_quaternion_unit.sv -----
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// ZYX Euler angles to unit quaternion: CORDIC sine and cosine, direction
// cosine matrix, Shepperd's selection, square root and reciprocal.
//
// Channels: angles (sink) takes roll, pitch and yaw as binary angles, a
// full turn being 2^ANGLE_BITS. quat (source) gives w, x, y, z in
// Q2.FRAC_BITS, saturated, w never negative, plus the dominant component.
// One transaction out for every transaction in, in order.
// Stages from input transaction to output valid: CORDIC load,
// 30 CORDIC cells and sign fix-up (32), 4 matrix and selection stages,
// 32 square root cells, 32 reciprocal stages, 3 output stages.
// One transaction per cycle unless quat stalls; every stage a single register.
// Reset clears all valid flags; the pipeline is empty after reset.
// When quat is stalled with a result waiting, the whole pipeline holds
// and angles.ready drops; bubbles do not compress.
// ----------------------------------------------------------------------------
module euler_to_quaternion_unit #(
  parameter int ANGLE_BITS = eul2q_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = eul2q_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  eul2q_angles_if.sink   angles,
  eul2q_quat_if.source   quat
);
  import eul2q_pkg::*;

  localparam int LAT        = CORDIC_STAGES + SQRT_STAGES + DIV_STAGES + 10;
  localparam int SIDE_DEPTH = SQRT_STAGES + DIV_STAGES + 1;
  localparam int SH         = WORK_FRAC - FRAC_BITS;
  localparam work_t RND     = (SH > 0) ? MW'(64'd1 << (SH - 1)) : '0;
  localparam work_t QONE    = MW'(64'd1 << FRAC_BITS);
  localparam work_t ONE     = MW'(64'd1 << WORK_FRAC);
  localparam work_t RAD_MAX = MW'(64'd8 << WORK_FRAC);

  logic           en;
  logic [LAT-1:0] vld;

  assign en          = !vld[LAT-1] || quat.ready;
  assign angles.ready = en;
  assign quat.valid  = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], angles.valid && en};
    end
  end

  // phase preparation and CORDIC
  logic [31:0] ph [3];
  logic        fl [3];
  logic signed [CW-1:0] cx [3][CORDIC_STAGES+1];
  logic signed [CW-1:0] cy [3][CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz [3][CORDIC_STAGES+1];
  logic                 cf [3][CORDIC_STAGES+1];

  assign ph[0] = 32'($unsigned(angles.roll_angle))  << (32 - ANGLE_BITS);
  assign ph[1] = 32'($unsigned(angles.pitch_angle)) << (32 - ANGLE_BITS);
  assign ph[2] = 32'($unsigned(angles.yaw_angle))   << (32 - ANGLE_BITS);

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign fl[l] = ph[l][31] ^ ph[l][30];

    always_ff @(posedge clk) begin
      if (en) begin
        cx[l][0] <= CW'($signed({1'b0, CORDIC_GAIN}));
        cy[l][0] <= '0;
        cz[l][0] <= ZW'($signed({fl[l] ? ~ph[l][31] : ph[l][31], ph[l][30:0]}));
        cf[l][0] <= fl[l];
      end
    end

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
      eul2q_cordic_cell #(.STAGE(s)) u_cell (
        .clk      (clk),
        .en       (en),
        .x_in     (cx[l][s]),
        .y_in     (cy[l][s]),
        .z_in     (cz[l][s]),
        .flip_in  (cf[l][s]),
        .x_out    (cx[l][s+1]),
        .y_out    (cy[l][s+1]),
        .z_out    (cz[l][s+1]),
        .flip_out (cf[l][s+1])
      );
    end
  end

  // sign fix-up
  logic signed [SCW-1:0] sn [3];
  logic signed [SCW-1:0] cs [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        if (cf[l][CORDIC_STAGES]) begin
          sn[l] <= SCW'(-cy[l][CORDIC_STAGES]);
          cs[l] <= SCW'(-cx[l][CORDIC_STAGES]);
        end else begin
          sn[l] <= SCW'(cy[l][CORDIC_STAGES]);
          cs[l] <= SCW'(cx[l][CORDIC_STAGES]);
        end
      end
    end
  end

  // first products
  work_t ss, csp, t00, t10, t20, t21, t22, a_m, b_m, c_m, d_m;
  logic signed [SCW-1:0] sps_d, cps_d;

  always_ff @(posedge clk) begin
    if (en) begin
      ss    <= qmul(MUL_W'(sn[0]), MUL_W'(sn[1]));
      csp   <= qmul(MUL_W'(cs[0]), MUL_W'(sn[1]));
      t00   <= qmul(MUL_W'(cs[1]), MUL_W'(cs[2]));
      a_m   <= qmul(MUL_W'(cs[0]), MUL_W'(sn[2]));
      b_m   <= qmul(MUL_W'(sn[0]), MUL_W'(sn[2]));
      t10   <= qmul(MUL_W'(cs[1]), MUL_W'(sn[2]));
      c_m   <= qmul(MUL_W'(cs[0]), MUL_W'(cs[2]));
      d_m   <= qmul(MUL_W'(sn[0]), MUL_W'(cs[2]));
      t20   <= -MW'(sn[1]);
      t21   <= qmul(MUL_W'(sn[0]), MUL_W'(cs[1]));
      t22   <= qmul(MUL_W'(cs[0]), MUL_W'(cs[1]));
      sps_d <= sn[2];
      cps_d <= cs[2];
    end
  end

  // direction cosine matrix
  work_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

  always_ff @(posedge clk) begin
    if (en) begin
      m00 <= t00;
      m01 <= -a_m + qmul(MUL_W'(ss), MUL_W'(cps_d));
      m02 <= b_m + qmul(MUL_W'(csp), MUL_W'(cps_d));
      m10 <= t10;
      m11 <= c_m + qmul(MUL_W'(ss), MUL_W'(sps_d));
      m12 <= -d_m + qmul(MUL_W'(csp), MUL_W'(sps_d));
      m20 <= t20;
      m21 <= t21;
      m22 <= t22;
    end
  end

  // trace and largest diagonal
  work_t n00, n01, n02, n10, n11, n12, n20, n21, n22, tr, best;
  logic [1:0] bi;
  work_t best_c;
  logic [1:0] bi_c;

  always_comb begin
    best_c = m00;
    bi_c   = 2'd0;
    if (m11 > best_c) begin
      best_c = m11;
      bi_c   = 2'd1;
    end
    if (m22 > best_c) begin
      best_c = m22;
      bi_c   = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n00  <= m00;
      n01  <= m01;
      n02  <= m02;
      n10  <= m10;
      n11  <= m11;
      n12  <= m12;
      n20  <= m20;
      n21  <= m21;
      n22  <= m22;
      tr   <= m00 + m11 + m22;
      best <= best_c;
      bi   <= bi_c;
    end
  end

  // selection and radicand
  logic [1:0] sel_c;
  work_t      rad_c;
  side_t      side_c;
  logic [RADW-1:0] rad_q;

  always_comb begin
    sel_c = (tr >= best) ? SEL_W : bi + 2'd1;
    side_c.sel = sel_c;
    unique case (sel_c)
      SEL_W: begin
        rad_c     = ONE + tr;
        side_c.p0 = n21 - n12;
        side_c.p1 = n02 - n20;
        side_c.p2 = n10 - n01;
      end
      SEL_X: begin
        rad_c     = ONE + (n00 <<< 1) - tr;
        side_c.p0 = n21 - n12;
        side_c.p1 = n01 + n10;
        side_c.p2 = n02 + n20;
      end
      SEL_Y: begin
        rad_c     = ONE + (n11 <<< 1) - tr;
        side_c.p0 = n02 - n20;
        side_c.p1 = n01 + n10;
        side_c.p2 = n12 + n21;
      end
      default: begin
        rad_c     = ONE + (n22 <<< 1) - tr;
        side_c.p0 = n10 - n01;
        side_c.p1 = n02 + n20;
        side_c.p2 = n12 + n21;
      end
    endcase
    if (rad_c < 0) begin
      rad_q = '0;
    end else if (rad_c > RAD_MAX) begin
      rad_q = RADW'(RAD_MAX);
    end else begin
      rad_q = RADW'(rad_c);
    end
  end

  side_t side [SIDE_DEPTH+1];

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_c;
      for (int k = 0; k < SIDE_DEPTH; k++) begin
        side[k+1] <= side[k];
      end
    end
  end

  // square root
  logic [SQW-1:0] sv [SQRT_STAGES+1];
  logic [SQW-1:0] sr [SQRT_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sv[0] <= {rad_q, WORK_FRAC'(0)};
      sr[0] <= '0;
    end
  end

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
    eul2q_sqrt_cell #(.STAGE(s)) u_cell (
      .clk     (clk),
      .en      (en),
      .v_in    (sv[s]),
      .res_in  (sr[s]),
      .v_out   (sv[s+1]),
      .res_out (sr[s+1])
    );
  end

  // reciprocal set-up
  logic [DOMW-1:0] dom_c;
  logic [DENW-1:0] den_c;
  logic [DENW-2:0] half_c;
  logic [DOMW-1:0] dom_d [DIV_STAGES+1];
  logic [DENW-1:0] dr [DIV_STAGES+1];
  logic [DENW-1:0] dd [DIV_STAGES+1];
  logic [RCPW-1:0] dn [DIV_STAGES+1];
  logic [RCPW-1:0] dq [DIV_STAGES+1];

  always_comb begin
    dom_c = sr[SQRT_STAGES][DOMW:1];
    den_c = {dom_c, 2'b00};
    if (den_c < (DENW'(1) << WORK_FRAC)) begin
      den_c = DENW'(1) << WORK_FRAC;
    end
    half_c = den_c[DENW-1:1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dom_d[0] <= dom_c;
      dr[0]    <= (DENW'(1) << (2 * WORK_FRAC - RCPW)) + DENW'(half_c[DENW-2]);
      dd[0]    <= den_c;
      dn[0]    <= half_c[RCPW-1:0];
      dq[0]    <= '0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dom_d[k+1] <= dom_d[k];
      end
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    eul2q_div_cell #(.BITPOS(DIV_STAGES - 1 - s)) u_cell (
      .clk     (clk),
      .en      (en),
      .rem_in  (dr[s]),
      .den_in  (dd[s]),
      .num_in  (dn[s]),
      .quo_in  (dq[s]),
      .rem_out (dr[s+1]),
      .den_out (dd[s+1]),
      .num_out (dn[s+1]),
      .quo_out (dq[s+1])
    );
  end

  // off-dominant components
  work_t f0, f1, f2;
  logic [DOMW-1:0] dom_f;
  logic [1:0] sel_f;
  logic signed [MUL_W-1:0] rcp_s;

  assign rcp_s = $signed({2'b00, dq[DIV_STAGES]});

  always_ff @(posedge clk) begin
    if (en) begin
      f0    <= qmul(rcp_s, MUL_W'(side[SIDE_DEPTH].p0));
      f1    <= qmul(rcp_s, MUL_W'(side[SIDE_DEPTH].p1));
      f2    <= qmul(rcp_s, MUL_W'(side[SIDE_DEPTH].p2));
      dom_f <= dom_d[DIV_STAGES];
      sel_f <= side[SIDE_DEPTH].sel;
    end
  end

  // arrange and fix sign
  work_t q_c [4];
  work_t dom_w;
  work_t qa [4];
  logic [1:0] sel_a;

  always_comb begin
    dom_w = MW'({1'b0, dom_f});
    unique case (sel_f)
      SEL_W: begin
        q_c[0] = dom_w; q_c[1] = f0; q_c[2] = f1; q_c[3] = f2;
      end
      SEL_X: begin
        q_c[0] = f0; q_c[1] = dom_w; q_c[2] = f1; q_c[3] = f2;
      end
      SEL_Y: begin
        q_c[0] = f0; q_c[1] = f1; q_c[2] = dom_w; q_c[3] = f2;
      end
      default: begin
        q_c[0] = f0; q_c[1] = f1; q_c[2] = f2; q_c[3] = dom_w;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        qa[k] <= q_c[0][MW-1] ? -q_c[k] : q_c[k];
      end
      sel_a <= sel_f;
    end
  end

  // round and saturate
  function automatic work_t to_out(input work_t v, input work_t lo);
    work_t r;
    r = (v + RND) >>> SH;
    if (r < lo) begin
      r = lo;
    end else if (r > QONE) begin
      r = QONE;
    end
    return r;
  endfunction

  work_t o_w, o_x, o_y, o_z;

  assign o_w = to_out(qa[0], '0);
  assign o_x = to_out(qa[1], -QONE);
  assign o_y = to_out(qa[2], -QONE);
  assign o_z = to_out(qa[3], -QONE);

  always_ff @(posedge clk) begin
    if (en) begin
      quat.quat_w        <= o_w[14:0];
      quat.quat_x        <= o_x[15:0];
      quat.quat_y        <= o_y[15:0];
      quat.quat_z        <= o_z[15:0];
      quat.dominant_case <= sel_a;
    end
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives angle triples into the Euler to quaternion pipeline with random
// gaps and output stalls, predicts each quaternion with a bit-exact CORDIC,
// Shepperd selection, square root and reciprocal, and checks in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import eul2q_pkg::*;

  typedef struct {
    logic [14:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [1:0]  dom;
  } quat_t;

  int err_count = 0;

  task automatic report(input string what, input longint got, input longint want);
    err_count++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  function automatic longint asr64(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint rmul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void cordic_sc(input logic [15:0] ang, output longint s,
                                    output longint c);
    logic [31:0] p;
    logic        flip;
    longint      x, y, z, dx, dy;
    p = {ang, 16'h0};
    flip = (p[31:30] == 2'd1) || (p[31:30] == 2'd2);
    x = CORDIC_GAIN;
    y = 0;
    if (flip) p = p - 32'h80000000;
    z = longint'($signed(p));
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_PHASE[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_PHASE[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint to_q14(input longint v, input longint lo, input longint hi);
    v = (v + (64'sd1 <<< 15)) >>> 16;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic quat_t euler_to_quat(input logic [15:0] r, input logic [15:0] p,
                                          input logic [15:0] yw);
    longint one, sph, cph, sth, cth, sps, cps, ss, cs;
    longint t00, t01, t02, t10, t11, t12, t20, t21, t22, tr, best, rad;
    longint dom, den, rcp, p0, p1, p2;
    longint q[4];
    logic [63:0] num;
    int bi, sel;
    quat_t o;
    one = 64'sd1 <<< 30;
    bi = 0;
    cordic_sc(r, sph, cph);
    cordic_sc(p, sth, cth);
    cordic_sc(yw, sps, cps);
    ss = rmul(sph, sth);
    cs = rmul(cph, sth);
    t00 = rmul(cth, cps);
    t01 = -rmul(cph, sps) + rmul(ss, cps);
    t02 = rmul(sph, sps) + rmul(cs, cps);
    t10 = rmul(cth, sps);
    t11 = rmul(cph, cps) + rmul(ss, sps);
    t12 = -rmul(sph, cps) + rmul(cs, sps);
    t20 = -sth;
    t21 = rmul(sph, cth);
    t22 = rmul(cph, cth);
    tr = t00 + t11 + t22;
    best = t00;
    if (t11 > best) begin best = t11; bi = 1; end
    if (t22 > best) begin best = t22; bi = 2; end
    sel = (tr >= best) ? SEL_W : bi + 1;
    case (sel)
      SEL_W:   rad = one + tr;
      SEL_X:   rad = one + 2 * t00 - tr;
      SEL_Y:   rad = one + 2 * t11 - tr;
      default: rad = one + 2 * t22 - tr;
    endcase
    if (rad < 0) rad = 0;
    if (rad > 8 * one) rad = 8 * one;
    dom = longint'(root64(64'(rad) << 30) >> 1);
    den = dom * 4;
    if (den < one) den = one;
    num = (64'd1 << 60) + 64'(den / 2);
    rcp = longint'(num / 64'(den));
    case (sel)
      SEL_W: begin p0 = t21 - t12; p1 = t02 - t20; p2 = t10 - t01; end
      SEL_X: begin p0 = t21 - t12; p1 = t01 + t10; p2 = t02 + t20; end
      SEL_Y: begin p0 = t02 - t20; p1 = t01 + t10; p2 = t12 + t21; end
      default: begin p0 = t10 - t01; p1 = t02 + t20; p2 = t12 + t21; end
    endcase
    p0 = rmul(rcp, p0);
    p1 = rmul(rcp, p1);
    p2 = rmul(rcp, p2);
    case (sel)
      SEL_W: begin q[0] = dom; q[1] = p0; q[2] = p1; q[3] = p2; end
      SEL_X: begin q[1] = dom; q[0] = p0; q[2] = p1; q[3] = p2; end
      SEL_Y: begin q[2] = dom; q[0] = p0; q[1] = p1; q[3] = p2; end
      default: begin q[3] = dom; q[0] = p0; q[1] = p1; q[2] = p2; end
    endcase
    if (q[0] < 0) for (int k = 0; k < 4; k++) q[k] = -q[k];
    o.w = 15'(to_q14(q[0], 0, 16384));
    o.x = 16'(to_q14(q[1], -16384, 16384));
    o.y = 16'(to_q14(q[2], -16384, 16384));
    o.z = 16'(to_q14(q[3], -16384, 16384));
    o.dom = 2'(sel);
    return o;
  endfunction

  class quat_scoreboard;
    quat_t pending[$];

    function void note_angles(logic [15:0] r, logic [15:0] p, logic [15:0] y);
      pending.push_back(euler_to_quat(r, p, y));
    endfunction

    task check_quat(quat_t got);
      quat_t want;
      if (pending.size() == 0) begin
        report("unexpected transaction", got.w, -1);
        return;
      end
      want = pending.pop_front();
      if (got.w != want.w) report("quat_w", got.w, want.w);
      if (got.x != want.x) report("quat_x", $signed(got.x), $signed(want.x));
      if (got.y != want.y) report("quat_y", $signed(got.y), $signed(want.y));
      if (got.z != want.z) report("quat_z", $signed(got.z), $signed(want.z));
      if (got.dom != want.dom) report("dominant_case", got.dom, want.dom);
    endtask
  endclass

  localparam int N_RANDOM = 1750;
  localparam int WATCHDOG = 5000;

  logic clk = 0;
  logic rst = 1;
  eul2q_angles_if angles ();
  eul2q_quat_if   quat ();
  quat_scoreboard sb = new();
  bit   calm = 0;
  bit   send_done = 0;
  int   idle_cycles = 0;

  euler_to_quaternion_unit dut (.clk(clk), .rst(rst), .angles(angles), .quat(quat));

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    angles.valid = 0;
    angles.roll_angle = 0;
    angles.pitch_angle = 0;
    angles.yaw_angle = 0;
    quat.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (angles.valid && angles.ready) begin
        sb.note_angles(angles.roll_angle, angles.pitch_angle, angles.yaw_angle);
      end
      if (quat.valid && quat.ready) begin
        quat_t g;
        g.w = quat.quat_w;
        g.x = quat.quat_x;
        g.y = quat.quat_y;
        g.z = quat.quat_z;
        g.dom = quat.dominant_case;
        sb.check_quat(g);
      end
      if ((angles.valid && angles.ready) || (quat.valid && quat.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_angles(input logic [15:0] r, input logic [15:0] p,
                             input logic [15:0] y);
    if (!calm && $urandom_range(0, 7) == 0) begin
      angles.valid <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    angles.valid <= 1;
    angles.roll_angle <= r;
    angles.pitch_angle <= p;
    angles.yaw_angle <= y;
    do @(posedge clk); while (!angles.ready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 4) * 16384 + $urandom_range(0, 6) - 3);
      1: return 16'($urandom_range(0, 7) * 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: long hold-off first, random stall bursts after
  initial begin
    @(negedge clk);
    wait (!rst);
    @(negedge clk);
    repeat (300) @(negedge clk);
    forever begin
      quat.ready <= 1;
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        quat.ready <= 0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
    end
  end

  initial begin
    logic [15:0] corner[8];
    corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000, 16'hC000,
               16'h0001, 16'h2000};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // extremes, gimbal lock at pitch of plus and minus a quarter turn,
    // half turns on each axis to steer each dominant component
    for (int i = 0; i < 8; i++) send_angles(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
    send_angles(16'h8000, 16'h0000, 16'h0000);
    send_angles(16'h0000, 16'h8000, 16'h0000);
    send_angles(16'h0000, 16'h0000, 16'h8000);
    send_angles(16'h8000, 16'h8000, 16'h0000);
    send_angles(16'h1234, 16'h4000, 16'h5678);
    send_angles(16'h1234, 16'hC000, 16'h5678);
    send_angles(16'h7000, 16'h0100, 16'h9000);
    send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
    send_angles(16'h5555, 16'hAAAA, 16'h5555);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 200) calm = 1;
      send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    angles.valid <= 0;
    send_done = 1;
  end

  initial begin
    wait (send_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
